// ===== design/wtv_pkg.sv =====
// ----------------------------------------------------------------------------
// wtv_pkg
// Shared types, constants and note increment tables for the wavetable voice.
// ----------------------------------------------------------------------------
package wtv_pkg;

    // table geometry and voice constants
    localparam int          C_TABLE_DEPTH = 256;
    localparam int          C_ADDR_W      = $clog2(C_TABLE_DEPTH);
    localparam int          C_ENV_LEN     = 255;
    localparam int          C_NOTE_COUNT  = 84;
    localparam int          C_ROM_NOTES   = 84;
    localparam logic [15:0] C_DELAY_RESET = 16'd300;

    // command queue between front and back
    localparam int C_QDEPTH = 2;

    // mode codes on the input channel
    typedef enum logic [1:0] {
        M_TICK      = 2'd0,
        M_NOTE_ON   = 2'd1,
        M_LOAD_WAVE = 2'd2,
        M_LOAD_ENV  = 2'd3
    } t_mode;

    // classified command kinds
    typedef enum logic [2:0] {
        K_NOP  = 3'd0,
        K_TICK = 3'd1,
        K_NOTE = 3'd2,
        K_WAVE = 3'd3,
        K_ENV  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           inc_whole;
        logic [7:0]           inc_frac;
        logic [C_ADDR_W-1:0]  addr;
        logic [7:0]           value;
    } t_cmd;

    // phase increment per note: whole part
    localparam logic [7:0] C_INC_WHOLE [C_ROM_NOTES] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3,
        8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5,
        8'd5, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd9, 8'd10,
        8'd10, 8'd11, 8'd11, 8'd12, 8'd13, 8'd14, 8'd14, 8'd15, 8'd16, 8'd17,
        8'd18, 8'd20, 8'd21, 8'd22, 8'd23, 8'd25, 8'd26, 8'd28, 8'd29, 8'd31,
        8'd33, 8'd35, 8'd37, 8'd40, 8'd42, 8'd44, 8'd47, 8'd50, 8'd53, 8'd56,
        8'd59, 8'd63, 8'd67, 8'd71
    };

    // phase increment per note: fractional byte
    localparam logic [7:0] C_INC_FRAC [C_ROM_NOTES] = '{
        8'd143, 8'd151, 8'd160, 8'd169, 8'd180, 8'd190, 8'd201, 8'd213, 8'd226, 8'd239,
        8'd254, 8'd14, 8'd30, 8'd47, 8'd64, 8'd83, 8'd104, 8'd125, 8'd147, 8'd171,
        8'd197, 8'd223, 8'd252, 8'd27, 8'd59, 8'd93, 8'd128, 8'd166, 8'd207, 8'd249,
        8'd39, 8'd87, 8'd138, 8'd191, 8'd248, 8'd53, 8'd117, 8'd185, 8'd1, 8'd77,
        8'd158, 8'd243, 8'd78, 8'd174, 8'd20, 8'd127, 8'd241, 8'd106, 8'd234, 8'd114,
        8'd2, 8'd154, 8'd60, 8'd230, 8'd156, 8'd92, 8'd40, 8'd254, 8'd226, 8'd212,
        8'd213, 8'd228, 8'd4, 8'd53, 8'd119, 8'd205, 8'd56, 8'd183, 8'd79, 8'd253,
        8'd134, 8'd104, 8'd170, 8'd127, 8'd8, 8'd105, 8'd238, 8'd155, 8'd112, 8'd111,
        8'd157, 8'd250, 8'd139, 8'd83
    };

endpackage

// ===== design/wtv_ram.sv =====
// ----------------------------------------------------------------------------
// wtv_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module wtv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/wtv_front.sv =====
// ----------------------------------------------------------------------------
// wtv_front
// Accepts input items, decodes them into commands (note range check and
// increment lookup) and buffers them in a short queue for the back end.
// ----------------------------------------------------------------------------
module wtv_front import wtv_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_mode,
    input  logic [6:0]          i_note,
    input  logic [C_ADDR_W-1:0] i_addr,
    input  logic [7:0]          i_value,
    output logic                o_q_valid,
    output t_cmd                o_q_cmd,
    input  logic                i_q_pop
);

    localparam int QPW = $clog2(C_QDEPTH);
    localparam int QCW = $clog2(C_QDEPTH + 1);

    t_cmd             c_cmd;
    logic             c_note_ok;
    logic [6:0]       c_rom_idx;
    logic             c_push;
    t_cmd             r_q [C_QDEPTH];
    logic [QPW-1:0]   r_wr_ptr;
    logic [QPW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic [QCW-1:0]   n_count;

    // decode the incoming transaction
    always_comb begin
        c_note_ok = ({1'b0, i_note} < 8'(C_NOTE_COUNT)) &&
                    ({1'b0, i_note} < 8'(C_ROM_NOTES));
        c_rom_idx = c_note_ok ? i_note : 7'd0;
        c_cmd.inc_whole = C_INC_WHOLE[c_rom_idx];
        c_cmd.inc_frac  = C_INC_FRAC[c_rom_idx];
        c_cmd.addr      = i_addr;
        c_cmd.value     = i_value;
        case (t_mode'(i_mode))
            M_TICK:      c_cmd.kind = K_TICK;
            M_NOTE_ON:   c_cmd.kind = c_note_ok ? K_NOTE : K_NOP;
            M_LOAD_WAVE: c_cmd.kind = K_WAVE;
            M_LOAD_ENV:  c_cmd.kind = K_ENV;
            default:     c_cmd.kind = K_NOP;
        endcase
    end

    assign o_ready   = (r_count != QCW'(C_QDEPTH));
    assign c_push    = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign o_q_cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (c_push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!c_push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (c_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wr_ptr] <= c_cmd;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(C_QDEPTH))
        else $error("command queue over depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_count != '0))
        else $error("pop from empty command queue");

endmodule

// ===== design/wtv_back.sv =====
// ----------------------------------------------------------------------------
// wtv_back
// Executes queued commands (phase accumulation, envelope steps, table loads,
// duty product), one command per cycle unless the output register stalls.
// ----------------------------------------------------------------------------
module wtv_back import wtv_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    input  logic                i_q_valid,
    input  t_cmd                i_q_cmd,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_duty,
    output logic                o_active
);

    // architectural state
    logic [15:0]         r_delay;
    logic                r_sounding,    n_sounding;
    logic [7:0]          r_env_pos,     n_env_pos;
    logic [15:0]         r_countdown,   n_countdown;
    logic [7:0]          r_env_level,   n_env_level;
    logic [7:0]          r_sample,      n_sample;
    logic [7:0]          r_inc_whole,   n_inc_whole;
    logic [7:0]          r_inc_frac,    n_inc_frac;
    logic [7:0]          r_phase_whole, n_phase_whole;
    logic [15:0]         r_phase_frac,  n_phase_frac;
    logic [C_ADDR_W-1:0] r_wave_pos,    n_wave_pos;
    logic [7:0]          r_duty,        n_duty;

    // output register
    logic                r_out_valid;
    logic [7:0]          r_out_duty;
    logic                r_out_active;

    // table read forwarding
    logic                r_wfwd_en;
    logic [7:0]          r_wfwd_data;
    logic                r_efwd_en;
    logic [7:0]          r_efwd_data;

    logic                c_pop;
    logic                c_wave_we;
    logic                c_env_we;
    logic [7:0]          c_wave_raw;
    logic [7:0]          c_env_raw;
    logic [7:0]          c_wave_rd;
    logic [7:0]          c_env_rd;
    logic [7:0]          c_env_pos_inc;
    logic [15:0]         c_product;

    assign c_pop     = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop   = c_pop;
    assign c_wave_we = c_pop && (i_q_cmd.kind == K_WAVE);
    assign c_env_we  = c_pop && (i_q_cmd.kind == K_ENV);

    // tables are read every cycle at the position the next tick will use
    wtv_ram #(.WIDTH(8), .DEPTH(C_TABLE_DEPTH)) u_wave_ram (
        .i_clk     (i_clk),
        .i_wr_en   (c_wave_we),
        .i_wr_addr (i_q_cmd.addr),
        .i_wr_data (i_q_cmd.value),
        .i_rd_addr (n_wave_pos),
        .o_rd_data (c_wave_raw)
    );

    wtv_ram #(.WIDTH(8), .DEPTH(C_TABLE_DEPTH)) u_env_ram (
        .i_clk     (i_clk),
        .i_wr_en   (c_env_we),
        .i_wr_addr (i_q_cmd.addr),
        .i_wr_data (i_q_cmd.value),
        .i_rd_addr (C_ADDR_W'(n_env_pos)),
        .o_rd_data (c_env_raw)
    );

    assign c_wave_rd     = r_wfwd_en ? r_wfwd_data : c_wave_raw;
    assign c_env_rd      = r_efwd_en ? r_efwd_data : c_env_raw;
    assign c_env_pos_inc = r_env_pos + 8'd1;

    // command execution
    always_comb begin
        n_sounding    = r_sounding;
        n_env_pos     = r_env_pos;
        n_countdown   = r_countdown;
        n_env_level   = r_env_level;
        n_sample      = r_sample;
        n_inc_whole   = r_inc_whole;
        n_inc_frac    = r_inc_frac;
        n_phase_whole = r_phase_whole;
        n_phase_frac  = r_phase_frac;
        n_wave_pos    = r_wave_pos;
        n_duty        = r_duty;
        c_product     = '0;
        if (c_pop) begin
            case (i_q_cmd.kind)
                K_TICK: begin
                    if (r_sounding) begin
                        n_sample = c_wave_rd;
                        if (r_countdown == 16'd0) begin
                            n_env_level = c_env_rd;
                            n_env_pos   = c_env_pos_inc;
                            n_countdown = r_delay;
                            if (c_env_pos_inc >= 8'(C_ENV_LEN)) begin
                                n_sounding = 1'b0;
                            end
                        end else begin
                            n_countdown = r_countdown - 16'd1;
                        end
                        n_phase_whole = r_phase_whole + r_inc_whole;
                        n_phase_frac  = r_phase_frac + {8'd0, r_inc_frac};
                        n_wave_pos    = C_ADDR_W'(n_phase_whole + n_phase_frac[15:8]);
                    end
                    c_product = n_sample * n_env_level;
                    n_duty    = c_product[14:7];
                end
                K_NOTE: begin
                    n_inc_whole = i_q_cmd.inc_whole;
                    n_inc_frac  = i_q_cmd.inc_frac;
                    n_env_pos   = 8'd0;
                    n_countdown = 16'd0;
                    n_sounding  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay       <= C_DELAY_RESET;
            r_sounding    <= 1'b0;
            r_env_pos     <= '0;
            r_countdown   <= '0;
            r_env_level   <= '0;
            r_sample      <= '0;
            r_inc_whole   <= '0;
            r_inc_frac    <= '0;
            r_phase_whole <= '0;
            r_phase_frac  <= '0;
            r_wave_pos    <= '0;
            r_duty        <= '0;
            r_out_valid   <= 1'b0;
            r_wfwd_en     <= 1'b0;
            r_efwd_en     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_delay <= i_cfg_wr_data;
            end
            r_sounding    <= n_sounding;
            r_env_pos     <= n_env_pos;
            r_countdown   <= n_countdown;
            r_env_level   <= n_env_level;
            r_sample      <= n_sample;
            r_inc_whole   <= n_inc_whole;
            r_inc_frac    <= n_inc_frac;
            r_phase_whole <= n_phase_whole;
            r_phase_frac  <= n_phase_frac;
            r_wave_pos    <= n_wave_pos;
            r_duty        <= n_duty;
            if (c_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            // a load to the address being read bypasses the stale RAM data
            r_wfwd_en <= c_wave_we && (i_q_cmd.addr == n_wave_pos);
            r_efwd_en <= c_env_we && (i_q_cmd.addr == C_ADDR_W'(n_env_pos));
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wfwd_data <= i_q_cmd.value;
        r_efwd_data <= i_q_cmd.value;
        if (c_pop) begin
            r_out_duty   <= n_duty;
            r_out_active <= n_sounding;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_duty   = r_out_duty;
    assign o_active = r_out_active;

    a_env_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sounding |-> (r_env_pos < 8'(C_ENV_LEN)))
        else $error("envelope position past table end with voice on");

    a_silent_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_pop && (i_q_cmd.kind == K_TICK) && !r_sounding)
        |=> ($stable(r_phase_frac) && $stable(r_wave_pos) && $stable(r_env_pos)))
        else $error("phase or envelope moved while voice off");

    a_duty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !c_pop |=> $stable(r_duty))
        else $error("duty changed without a command");

    a_result_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_pop |=> r_out_valid)
        else $error("executed command produced no result");

endmodule

// ===== design/wavetable_voice_with_envelope.sv =====
// ----------------------------------------------------------------------------
// wavetable_voice_with_envelope
// Single-voice wavetable oscillator with a table-driven envelope and PWM duty.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser selects tick, note on,
//   wave table load or envelope table load; tdata holds note and table fields.
//   m_axis returns exactly one result per command: the PWM duty in tdata and
//   the voice-active flag in tuser, in command order.
//   i_cfg_wr_en/i_cfg_wr_data set the envelope step delay (ticks minus one);
//   write it only while no commands are in flight.
//   A command accepted into an empty queue is queued, then executed into the
//   output register. Throughput: one command per cycle unless m_axis stalls,
//   set by the single execute stage and registered wave/envelope table reads.
//   A two-entry command queue separates input from execution and the output
//   register separates execution from the receiver; when m_axis stalls the
//   queue fills and s_axis_tready drops after two more commands.
//   Reset returns the voice to off with zero phase, duty and increments and
//   the delay to 300; table contents are kept and must be loaded before use.
// ----------------------------------------------------------------------------
module wavetable_voice_with_envelope import wtv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // note_index[6:0], table_address[14:7],
                                        // table_value[22:15], zero pad[23]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // pwm_duty[7:0]
    output logic [0:0]  m_axis_tuser    // voice_active[0]
);

    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    logic out_active;

    // input decode and command queue
    wtv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_mode    (s_axis_tuser),
        .i_note    (s_axis_tdata[6:0]),
        .i_addr    (s_axis_tdata[14:7]),
        .i_value   (s_axis_tdata[22:15]),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    // voice execution and result register
    wtv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_duty        (m_axis_tdata),
        .o_active      (out_active)
    );

    assign m_axis_tuser = out_active;

endmodule
